/* sv/alle_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// alle_pkg
// shared types and codes for the array linked list engine
// ----------------------------------------------------------------------------
package alle_pkg;

    typedef enum logic [2:0] {
        CMD_INS_FRONT  = 3'd0,
        CMD_INS_BACK   = 3'd1,
        CMD_INS_BEFORE = 3'd2,
        CMD_INS_AFTER  = 3'd3,
        CMD_DELETE     = 3'd4,
        CMD_READ       = 3'd5,
        CMD_SEARCH     = 3'd6,
        CMD_NONE       = 3'd7
    } t_cmd;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADPOS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [1:0] REG_TOL = 2'd0;

    localparam logic [30:0] TOL_RESET = 31'd7;

endpackage
`default_nettype wire

/* sv/alle_cmp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// alle_cmp
// tolerance compare unit used by the search walk
// ----------------------------------------------------------------------------
module alle_cmp #(
    parameter int DATA_BITS = 32
) (
    input  wire logic [DATA_BITS-1:0] i_a,
    input  wire logic [DATA_BITS-1:0] i_b,
    input  wire logic [30:0]          i_tol,
    output logic                      o_match
);
    // compare width covers both the difference and the tolerance
    localparam int CMPW = (DATA_BITS + 1 > 31) ? DATA_BITS + 1 : 31;

    logic signed [DATA_BITS:0] w_diff;
    logic        [DATA_BITS:0] w_abs;

    // absolute difference against tolerance
    always_comb begin
        w_diff = $signed({i_a[DATA_BITS-1], i_a}) - $signed({i_b[DATA_BITS-1], i_b});
        w_abs  = w_diff[DATA_BITS] ? (~w_diff + 1'b1) : w_diff;
        o_match = (CMPW'(w_abs) <= CMPW'(i_tol));
    end
endmodule
`default_nettype wire

/* sv/array_linked_list_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// array_linked_list_engine
// doubly linked list over a slot pool with a free-slot stack
// ----------------------------------------------------------------------------
// One command at a time; o_stall stays high from the accepted transfer until
// the result is taken. Links and data live in single-read-port memories, so a
// command takes its memory accesses one at a time in separate states, and a
// search visits the slots in turn, skipping free slots without a memory read.
// The free stack is held in a memory with a fill count and the used flags are
// flip-flops cleared at reset; no clearing pass is needed.
module array_linked_list_engine #(
    parameter int SLOTS     = 255,
    parameter int DATA_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_command,
    input  wire logic [7:0]  i_position,
    input  wire logic signed [31:0] i_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [7:0]       o_slot,
    output logic [7:0]       o_next_slot,
    output logic [7:0]       o_prev_slot,
    output logic signed [31:0] o_slot_data,
    output logic [7:0]       o_head_slot,
    output logic [7:0]       o_tail_slot,
    output logic [7:0]       o_free_count,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int IW = $clog2(SLOTS + 1);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST = IW'(SLOTS);

    typedef enum logic [3:0] {
        S_IDLE, S_RDA, S_RDB, S_LINK1, S_LINK2, S_DEL1, S_DEL2,
        S_SRD, S_SCMP, S_RESP
    } t_state;

    t_state               r_state;
    logic [2:0]           r_cmd;
    logic [IW-1:0]        r_pos;
    logic [DATA_BITS-1:0] r_val;
    logic [30:0]          r_tol;
    logic [IW-1:0]        r_s;
    logic [IW-1:0]        r_p;
    logic [IW-1:0]        r_n;
    logic [IW-1:0]        r_head;
    logic [IW-1:0]        r_tail;
    logic [CW-1:0]        r_depth;
    logic [CW-1:0]        r_init;
    logic [SLOTS:0]       r_used;
    logic [1:0]           r_status;
    logic [7:0]           r_slot, r_nx, r_pv;
    logic [31:0]          r_data;

    // link and data memories, one read port each
    logic [IW-1:0]        mem_next [SLOTS+1];
    logic [IW-1:0]        mem_prev [SLOTS+1];
    logic [DATA_BITS-1:0] mem_data [SLOTS+1];
    logic [IW-1:0]        mem_free [SLOTS];
    logic [IW-1:0]        r_rd_next, r_rd_prev, r_rd_free;
    logic [DATA_BITS-1:0] r_rd_data;

    logic [IW-1:0]        w_raddr;
    logic [CW-1:0]        w_faddr;
    logic                 w_match;
    logic                 w_acc;
    logic                 w_pos_ok;
    logic                 w_cfg_wr;
    logic [IW-1:0]        w_fslot;

    assign pready   = 1'b1;
    assign prdata   = {1'b0, r_tol};
    assign w_cfg_wr = psel && penable && pwrite && (paddr == alle_pkg::REG_TOL);
    assign o_stall  = (r_state != S_IDLE);
    assign w_acc    = i_valid && (r_state == S_IDLE);
    assign o_valid  = (r_state == S_RESP);
    assign o_status = r_status;
    assign o_slot = r_slot;
    assign o_next_slot = r_nx;
    assign o_prev_slot = r_pv;
    assign o_slot_data = r_data;
    assign o_head_slot = 8'(r_head);
    assign o_tail_slot = 8'(r_tail);
    assign o_free_count = (r_depth > CW'(255)) ? 8'd255 : 8'(r_depth);
    assign w_pos_ok = (r_pos != '0) && (r_pos <= LAST) && r_used[r_pos];
    // stack entries below the lowest depth ever reached hold their reset pattern
    assign w_fslot = (w_faddr < r_init) ? IW'(SLOTS - int'(w_faddr)) : r_rd_free;

    alle_cmp #(.DATA_BITS(DATA_BITS)) u_cmp (
        .i_a(r_rd_data), .i_b(r_val), .i_tol(r_tol), .o_match(w_match)
    );

    assign w_raddr = (r_state == S_SRD || r_state == S_SCMP) ? r_s : r_pos;
    assign w_faddr = r_depth - 1'b1;

    // registered memory reads
    always_ff @(posedge i_clk) begin
        r_rd_next <= mem_next[w_raddr];
        r_rd_prev <= mem_prev[w_raddr];
        r_rd_data <= mem_data[w_raddr];
        r_rd_free <= mem_free[w_faddr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tol   <= alle_pkg::TOL_RESET;
            r_head  <= '0;
            r_tail  <= '0;
            r_depth <= CW'(SLOTS);
            r_init  <= CW'(SLOTS);
            r_used  <= '0;
        end else begin
            if (w_cfg_wr) r_tol <= pwdata[30:0];
            unique case (r_state)
                S_IDLE: if (w_acc) begin
                    r_cmd   <= i_command;
                    r_pos   <= IW'(i_position);
                    r_val   <= DATA_BITS'($signed(i_value));
                    r_s     <= IW'(1);
                    r_status <= alle_pkg::ST_OK;
                    r_slot <= '0; r_nx <= '0; r_pv <= '0; r_data <= '0;
                    r_state <= S_RDA;
                end
                S_RDA: r_state <= (r_cmd == alle_pkg::CMD_SEARCH) ? S_SRD : S_RDB;
                S_RDB: begin
                    // read data of position and stack top are valid now
                    priority if (r_cmd == alle_pkg::CMD_NONE) begin
                        r_status <= alle_pkg::ST_BADPOS;
                        r_state  <= S_RESP;
                    end else if (r_cmd[2] || r_cmd[1]) begin
                        if (!w_pos_ok) begin
                            r_status <= alle_pkg::ST_BADPOS;
                            r_state  <= S_RESP;
                        end else if (r_cmd[2]) begin
                            r_slot <= 8'(r_pos);
                            r_nx   <= 8'(r_rd_next);
                            r_pv   <= 8'(r_rd_prev);
                            r_data <= 32'($signed(r_rd_data));
                            r_p <= r_rd_prev;
                            r_n <= r_rd_next;
                            r_state <= (r_cmd == alle_pkg::CMD_DELETE) ? S_DEL1 : S_RESP;
                        end else if (r_depth == '0) begin
                            r_status <= alle_pkg::ST_FULL;
                            r_state  <= S_RESP;
                        end else begin
                            r_s <= w_fslot;
                            r_p <= (r_cmd == alle_pkg::CMD_INS_BEFORE) ? r_rd_prev : r_pos;
                            r_n <= (r_cmd == alle_pkg::CMD_INS_BEFORE) ? r_pos : r_rd_next;
                            r_state <= S_LINK1;
                        end
                    end else if (r_depth == '0) begin
                        r_status <= alle_pkg::ST_FULL;
                        r_state  <= S_RESP;
                    end else begin
                        r_s <= w_fslot;
                        r_p <= (r_cmd == alle_pkg::CMD_INS_FRONT) ? '0 : r_tail;
                        r_n <= (r_cmd == alle_pkg::CMD_INS_FRONT) ? r_head : '0;
                        r_state <= S_LINK1;
                    end
                end
                S_LINK1: begin
                    mem_data[r_s] <= r_val;
                    mem_next[r_s] <= r_n;
                    mem_prev[r_s] <= r_p;
                    r_used[r_s]   <= 1'b1;
                    r_depth <= r_depth - 1'b1;
                    if (w_faddr < r_init) r_init <= w_faddr;
                    r_slot <= 8'(r_s);
                    r_nx   <= 8'(r_n);
                    r_pv   <= 8'(r_p);
                    r_data <= 32'($signed(r_val));
                    r_state <= S_LINK2;
                end
                S_LINK2: begin
                    if (r_p == '0) r_head <= r_s; else mem_next[r_p] <= r_s;
                    if (r_n == '0) r_tail <= r_s; else mem_prev[r_n] <= r_s;
                    r_state <= S_RESP;
                end
                S_DEL1: begin
                    if (r_n == '0) r_tail <= r_p; else mem_prev[r_n] <= r_p;
                    if (r_p == '0) r_head <= r_n; else mem_next[r_p] <= r_n;
                    r_used[r_pos] <= 1'b0;
                    r_state <= S_DEL2;
                end
                S_DEL2: begin
                    if (r_depth < CW'(SLOTS)) begin
                        mem_free[r_depth[CW-1:0]] <= r_pos;
                        r_depth <= r_depth + 1'b1;
                    end
                    r_state <= S_RESP;
                end
                S_SRD: begin
                    // skip free slots without a memory read
                    if (!r_used[r_s]) begin
                        if (r_s == LAST) begin
                            r_status <= alle_pkg::ST_NOTFOUND;
                            r_state  <= S_RESP;
                        end else r_s <= r_s + 1'b1;
                    end else r_state <= S_SCMP;
                end
                S_SCMP: begin
                    if (w_match) begin
                        r_slot <= 8'(r_s);
                        r_nx   <= 8'(r_rd_next);
                        r_pv   <= 8'(r_rd_prev);
                        r_data <= 32'($signed(r_rd_data));
                        r_state <= S_RESP;
                    end else if (r_s == LAST) begin
                        r_status <= alle_pkg::ST_NOTFOUND;
                        r_state  <= S_RESP;
                    end else begin
                        r_s <= r_s + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_RESP: if (!i_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // free depth bound, failure slot, result hold and empty-list head checks
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CW'(SLOTS)) else $error("free depth overflow");
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != alle_pkg::ST_OK) |-> (o_slot == 8'd0))
        else $error("failure with slot");
    a_nohold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_slot))
        else $error("result dropped");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth == CW'(SLOTS)) && (r_state == S_IDLE) |-> (r_head == '0))
        else $error("empty list has head");
`endif
endmodule
`default_nettype wire

/* dv/alle_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_checker
// watches both channels and the register port of the list engine, keeps its own
// copy of the slot pool, the links and the free stack, and compares every result
// transfer field by field with the oldest predicted result
// ----------------------------------------------------------------------------
module alle_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_stall_in,
    input  wire logic [2:0]  i_command,
    input  wire logic [7:0]  i_position,
    input  wire logic [31:0] i_value,
    input  wire logic        i_res_valid,
    input  wire logic        i_res_stall,
    input  wire logic [1:0]  i_status,
    input  wire logic [7:0]  i_slot,
    input  wire logic [7:0]  i_next_slot,
    input  wire logic [7:0]  i_prev_slot,
    input  wire logic [31:0] i_slot_data,
    input  wire logic [7:0]  i_head_slot,
    input  wire logic [7:0]  i_tail_slot,
    input  wire logic [7:0]  i_free_count,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic        i_pready,
    input  wire logic [1:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output int               o_errors,
    output int               o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot;
        logic [7:0]  nxt;
        logic [7:0]  prv;
        logic [31:0] data;
        logic [7:0]  head;
        logic [7:0]  tail;
        logic [7:0]  free;
    } t_list_result;

    localparam int NSLOT = 255;

    t_list_result pending_results[$];
    logic [31:0]  slot_mem [0:NSLOT];
    logic [7:0]   nxt_mem  [0:NSLOT];
    logic [7:0]   prv_mem  [0:NSLOT];
    logic         in_use   [0:NSLOT];
    logic [7:0]   free_stk [0:NSLOT-1];
    int           free_top;
    logic [30:0]  tolerance;

    assign o_pending = pending_results.size();

    // allocate a free slot and link it between two neighbors
    function automatic t_list_result link_new(logic [7:0] p, logic [7:0] n,
                                              logic [31:0] v);
        t_list_result r;
        logic [7:0] s;
        r = '0;
        free_top--;
        s = free_stk[free_top];
        slot_mem[s] = v;
        nxt_mem[s] = n;
        prv_mem[s] = p;
        in_use[s] = 1'b1;
        nxt_mem[p] = s;
        prv_mem[n] = s;
        r.slot = s;
        r.nxt = n;
        r.prv = p;
        r.data = v;
        return r;
    endfunction

    // apply one command to the list copy and build its result
    function automatic t_list_result apply_command(alle_pkg::t_cmd c, logic [7:0] pos,
                                                   logic [31:0] v);
        t_list_result r;
        logic pos_ok;
        logic [31:0] diff;
        r = '0;
        r.status = alle_pkg::ST_OK;
        pos_ok = (pos != 8'd0) && in_use[pos];
        case (c)
            alle_pkg::CMD_INS_FRONT, alle_pkg::CMD_INS_BACK,
            alle_pkg::CMD_INS_BEFORE, alle_pkg::CMD_INS_AFTER: begin
                if ((c == alle_pkg::CMD_INS_BEFORE || c == alle_pkg::CMD_INS_AFTER) &&
                    !pos_ok) begin
                    r.status = alle_pkg::ST_BADPOS;
                end else if (free_top == 0) begin
                    r.status = alle_pkg::ST_FULL;
                end else if (c == alle_pkg::CMD_INS_FRONT) begin
                    r = link_new(8'd0, nxt_mem[0], v);
                end else if (c == alle_pkg::CMD_INS_BACK) begin
                    r = link_new(prv_mem[0], 8'd0, v);
                end else if (c == alle_pkg::CMD_INS_BEFORE) begin
                    r = link_new(prv_mem[pos], pos, v);
                end else begin
                    r = link_new(pos, nxt_mem[pos], v);
                end
            end
            alle_pkg::CMD_DELETE, alle_pkg::CMD_READ: begin
                if (!pos_ok) begin
                    r.status = alle_pkg::ST_BADPOS;
                end else begin
                    r.slot = pos;
                    r.nxt = nxt_mem[pos];
                    r.prv = prv_mem[pos];
                    r.data = slot_mem[pos];
                    if (c == alle_pkg::CMD_DELETE) begin
                        prv_mem[r.nxt] = r.prv;
                        nxt_mem[r.prv] = r.nxt;
                        in_use[pos] = 1'b0;
                        free_stk[free_top] = pos;
                        free_top++;
                    end
                end
            end
            alle_pkg::CMD_SEARCH: begin
                r.status = alle_pkg::ST_NOTFOUND;
                for (int i = 1; i <= NSLOT; i++) begin
                    if (in_use[i] && r.status == alle_pkg::ST_NOTFOUND) begin
                        // signed compare, then unsigned magnitude of difference
                        diff = ($signed(slot_mem[i]) >= $signed(v)) ?
                               slot_mem[i] - v : v - slot_mem[i];
                        if (diff <= {1'b0, tolerance}) begin
                            r.status = alle_pkg::ST_OK;
                            r.slot = i[7:0];
                            r.nxt = nxt_mem[i];
                            r.prv = prv_mem[i];
                            r.data = slot_mem[i];
                        end
                    end
                end
            end
            default: r.status = alle_pkg::ST_BADPOS;
        endcase
        r.head = nxt_mem[0];
        r.tail = prv_mem[0];
        r.free = free_top[7:0];
        return r;
    endfunction

    // predict on input transfers, compare on result transfers
    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        if (!i_rst_n) begin
            pending_results.delete();
            o_errors <= 0;
            tolerance = alle_pkg::TOL_RESET;
            for (int i = 0; i <= NSLOT; i++) begin
                in_use[i] = 1'b0;
            end
            nxt_mem[0] = 8'd0;
            prv_mem[0] = 8'd0;
            for (int i = 0; i < NSLOT; i++) begin
                free_stk[i] = 8'(NSLOT - i);
            end
            free_top = NSLOT;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == alle_pkg::REG_TOL) begin
                tolerance = i_pwdata[30:0];
            end
            if (i_valid && !i_stall_in) begin
                pending_results.push_back(apply_command(alle_pkg::t_cmd'(i_command),
                                                        i_position, i_value));
            end
            if (i_res_valid && !i_res_stall) begin
                got = {i_status, i_slot, i_next_slot, i_prev_slot, i_slot_data,
                       i_head_slot, i_tail_slot, i_free_count};
                if (pending_results.size() == 0) begin
                    if (o_errors < 10) begin
                        $display("unexpected result transfer: %h", got);
                    end
                    o_errors <= o_errors + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        if (o_errors < 10) begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  status exp %0d got %0d, slot exp %0d got %0d",
                                     want.status, got.status, want.slot, got.slot);
                            $display("  next exp %0d got %0d, prev exp %0d got %0d",
                                     want.nxt, got.nxt, want.prv, got.prv);
                            $display("  data exp %h got %h", want.data, got.data);
                            $display("  head %0d/%0d tail %0d/%0d free %0d/%0d",
                                     want.head, got.head, want.tail, got.tail,
                                     want.free, got.free);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives commands and tolerance writes into the list engine with random gaps
// and back-pressure; the checker predicts and compares, this module decides
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    logic [2:0]  cmd_code = '0;
    logic [7:0]  cmd_pos = '0;
    logic [31:0] cmd_value = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [1:0]  res_status;
    logic [7:0]  res_slot, res_next, res_prev, res_head, res_tail, res_free;
    logic [31:0] res_data;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          error_count;
    int          pending_count;
    int          idle_cycles = 0;
    logic        stall_storm = 1'b0;

    // mirror of which slots are live, so most positions hit a real slot
    logic        live [1:255];
    int          live_total = 0;
    logic [7:0]  del_q[$];

    always #5 i_clk = ~i_clk;

    array_linked_list_engine DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(cmd_valid), .o_stall(cmd_stall),
        .i_command(cmd_code), .i_position(cmd_pos), .i_value(cmd_value),
        .o_valid(res_valid), .i_stall(res_stall),
        .o_status(res_status), .o_slot(res_slot), .o_next_slot(res_next),
        .o_prev_slot(res_prev), .o_slot_data(res_data), .o_head_slot(res_head),
        .o_tail_slot(res_tail), .o_free_count(res_free),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    alle_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(cmd_valid), .i_stall_in(cmd_stall),
        .i_command(cmd_code), .i_position(cmd_pos), .i_value(cmd_value),
        .i_res_valid(res_valid), .i_res_stall(res_stall),
        .i_status(res_status), .i_slot(res_slot), .i_next_slot(res_next),
        .i_prev_slot(res_prev), .i_slot_data(res_data), .i_head_slot(res_head),
        .i_tail_slot(res_tail), .i_free_count(res_free),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_errors(error_count), .o_pending(pending_count)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure, with bursts of none and heavy stretches
    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) begin
            stall_storm <= ~stall_storm;
        end
        if (stall_storm) begin
            res_stall <= 1'b0;
        end else if (res_stall) begin
            res_stall <= ($urandom_range(0, 99) < 60);
        end else begin
            res_stall <= ($urandom_range(0, 99) < 20);
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic reg_write(logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= alle_pkg::REG_TOL;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending_count != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    // one command transfer, valid held until accepted
    task automatic send_cmd(alle_pkg::t_cmd c, logic [7:0] pos, logic [31:0] v);
        int g;
        g = gap_len();
        if (g > 0) begin
            cmd_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        cmd_valid <= 1'b1;
        cmd_code <= c;
        cmd_pos <= pos;
        cmd_value <= v;
        @(posedge i_clk);
        while (cmd_stall) @(posedge i_clk);
        // track live slots from the known allocation order is hard, so track by result
    endtask

    function automatic logic [7:0] pick_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 8'd0;
        if (r < 18) return 8'($urandom_range(0, 255));
        if (live_total > 0) begin
            for (int k = 0; k < 64; k++) begin
                r = $urandom_range(1, 255);
                if (live[r]) return 8'(r);
            end
        end
        return 8'($urandom_range(1, 20));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 40)) - 32'd20;
            default: return $urandom();
        endcase
    endfunction

    // keep the live mirror current from accepted results; deletes clear the entry
    always @(posedge i_clk) begin
        logic is_del;
        if (!i_rst_n) begin
            for (int i = 1; i < 256; i++) live[i] <= 1'b0;
            live_total <= 0;
            del_q.delete();
        end else begin
            if (cmd_valid && !cmd_stall) begin
                del_q.push_back(cmd_code == alle_pkg::CMD_DELETE ? cmd_pos : 8'd0);
            end
            if (res_valid && !res_stall) begin
                is_del = 1'b0;
                if (del_q.size() > 0) begin
                    is_del = (del_q.pop_front() != 8'd0);
                end
                if (res_status == alle_pkg::ST_OK && res_slot != 8'd0) begin
                    live[res_slot] <= !is_del;
                end
                live_total <= 255 - res_free;
            end
        end
    end

    task automatic random_phase(int count, int insert_bias);
        int r;
        alle_pkg::t_cmd c;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < insert_bias) begin
                c = alle_pkg::t_cmd'($urandom_range(0, 3));
            end else if (r < insert_bias + 20) begin
                c = alle_pkg::CMD_DELETE;
            end else if (r < insert_bias + 35) begin
                c = alle_pkg::CMD_READ;
            end else if (r < 98) begin
                c = alle_pkg::CMD_SEARCH;
            end else begin
                c = alle_pkg::CMD_NONE;
            end
            send_cmd(c, pick_pos(), pick_value());
        end
        cmd_valid <= 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-list errors, inserts, links, search edges, unknown code
        send_cmd(alle_pkg::CMD_READ, 8'd0, 32'd0);
        send_cmd(alle_pkg::CMD_DELETE, 8'd1, 32'd0);
        send_cmd(alle_pkg::CMD_SEARCH, 8'd0, 32'd0);
        send_cmd(alle_pkg::CMD_INS_BEFORE, 8'd1, 32'd5);
        send_cmd(alle_pkg::CMD_INS_FRONT, 8'd0, 32'h8000_0000);
        send_cmd(alle_pkg::CMD_INS_BACK, 8'd255, 32'h7fff_ffff);
        send_cmd(alle_pkg::CMD_INS_BEFORE, 8'd2, 32'd100);
        send_cmd(alle_pkg::CMD_INS_AFTER, 8'd1, 32'hffff_ffff);
        send_cmd(alle_pkg::CMD_INS_AFTER, 8'd0, 32'd1);
        send_cmd(alle_pkg::CMD_READ, 8'd3, 32'd0);
        send_cmd(alle_pkg::CMD_SEARCH, 8'd0, 32'd107);
        send_cmd(alle_pkg::CMD_SEARCH, 8'd0, 32'd108);
        send_cmd(alle_pkg::CMD_SEARCH, 8'd0, 32'h7fff_fff9);
        send_cmd(alle_pkg::CMD_SEARCH, 8'd0, 32'h7fff_fff8);
        send_cmd(alle_pkg::CMD_DELETE, 8'd1, 32'd0);
        send_cmd(alle_pkg::CMD_READ, 8'd1, 32'd0);
        send_cmd(alle_pkg::CMD_INS_FRONT, 8'd0, 32'd42);
        send_cmd(alle_pkg::CMD_NONE, 8'd3, 32'd0);
        send_cmd(alle_pkg::CMD_DELETE, 8'd255, 32'd0);
        cmd_valid <= 1'b0;
        drain();

        // wide tolerance lets search span the full signed range
        reg_write(32'h7fff_ffff);
        send_cmd(alle_pkg::CMD_SEARCH, 8'd0, 32'h8000_0000);
        send_cmd(alle_pkg::CMD_SEARCH, 8'd0, 32'h7fff_ffff);
        cmd_valid <= 1'b0;
        drain();
        reg_write(32'hffff_ffff);
        random_phase(150, 60);
        drain();

        // fill the pool to the top, then push inserts against a full pool
        reg_write(32'd0);
        random_phase(350, 85);
        for (int n = 0; n < 15; n++) begin
            send_cmd(alle_pkg::t_cmd'(n % 4), pick_pos(), pick_value());
        end
        cmd_valid <= 1'b0;
        drain();

        reg_write(32'd7);
        random_phase(350, 25);
        drain();
        reg_write(32'($urandom_range(0, 1 << 20)));
        random_phase(300, 45);
        drain();
        reg_write(32'($urandom()));
        random_phase(250, 40);
        drain();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
